@@ src/integer_to_ascii_formatter_defines.svh @@
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define ITAF_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ITAF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/itaf_pkg.sv @@
// shared constants, types and helpers of the integer to ascii formatter
`default_nettype none

package itaf_pkg;

    localparam int VALUE_WIDTH    = 32;
    localparam int ADDRESS_DIGITS = 9;
    localparam int IN_WIDTH       = 32;

    localparam int DEC_DIGITS = (VALUE_WIDTH * 302) / 1000 + 1;
    localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int ADDR_SLOTS = (HEX_DIGITS > ADDRESS_DIGITS) ? HEX_DIGITS : ADDRESS_DIGITS;
    localparam int NDIG_A     = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
    localparam int NDIG       = (NDIG_A > ADDR_SLOTS) ? NDIG_A : ADDR_SLOTS;
    localparam int CNT_W      = $clog2(NDIG + 1);
    localparam int IDX_W      = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int BIT_W      = $clog2(VALUE_WIDTH + 1);

    localparam logic [CNT_W-1:0] CNT_DEC  = CNT_W'(DEC_DIGITS);
    localparam logic [CNT_W-1:0] CNT_HEX  = CNT_W'(HEX_DIGITS);
    localparam logic [CNT_W-1:0] CNT_OCT  = CNT_W'(OCT_DIGITS);
    localparam logic [CNT_W-1:0] CNT_ADDR = CNT_W'(ADDR_SLOTS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] MIN_ADDR = CNT_W'(ADDRESS_DIGITS);
    localparam logic [BIT_W-1:0] BITS_ALL = BIT_W'(VALUE_WIDTH);
    localparam logic [BIT_W-1:0] BITS_ONE = BIT_W'(1);

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_HEXL = 3'd2;
    localparam logic [2:0] KIND_HEXU = 3'd3;
    localparam logic [2:0] KIND_OCT  = 3'd4;
    localparam logic [2:0] KIND_ADDR = 3'd5;

    localparam logic [7:0] ASCII_ZERO       = 8'd48;
    localparam logic [7:0] ASCII_MINUS      = 8'd45;
    localparam logic [7:0] LOWER_HEX_OFFSET = 8'd87;
    localparam logic [7:0] UPPER_HEX_OFFSET = 8'd55;
    localparam logic [3:0] DIGIT_NINE       = 4'd9;
    localparam logic [3:0] BCD_FIVE         = 4'd5;
    localparam logic [3:0] BCD_THREE        = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef logic [NDIG-1:0][3:0] digits_t;

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] off;
        off = upper ? UPPER_HEX_OFFSET : LOWER_HEX_OFFSET;
        return (d > DIGIT_NINE) ? (8'(d) + off) : (8'(d) + ASCII_ZERO);
    endfunction

endpackage

`default_nettype wire

@@ src/integer_to_ascii_formatter.sv @@
// integer to ascii formatter: 32-bit value in, one ascii character per output word
// sequence: decimal kinds load, run the double-dabble over all VALUE_WIDTH bits,
// emit a sign word if negative, then scan the digit slots (10); hex scans 8
// slots, address 9 and octal 11, straight after the load; one slot is scanned per
// cycle while the output is free, and a new value is taken only back in idle
// reset: synchronous active-low aresetn returns the sequencer to idle, no word pending
`default_nettype none
`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter
    import itaf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [2:0]          s_kind,
    input  wire logic [IN_WIDTH-1:0] s_value,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_character,
    output logic                     m_last
);

    state_t               state_reg, state_next;
    digits_t              dig_reg, dig_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BIT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     min_reg, min_next;
    logic                 upper_reg, upper_next;
    logic                 neg_reg, neg_next;
    logic                 started_reg, started_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;

    logic                 in_take, out_free;
    logic [VALUE_WIDTH-1:0] v_ext, mag;
    logic                 v_neg;
    logic [OCT_DIGITS*3-1:0] v_oct;
    logic [HEX_DIGITS*4-1:0] v_hex;
    digits_t              oct_slots, hex_slots, dabble;
    logic [3:0]           cur_digit;
    logic                 show_digit;

    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign v_ext = VALUE_WIDTH'(s_value);
    assign v_neg = (s_kind == KIND_SDEC) && v_ext[VALUE_WIDTH-1];
    assign mag   = v_neg ? (~v_ext + VALUE_WIDTH'(1)) : v_ext;
    assign v_oct = (OCT_DIGITS*3)'(v_ext);
    assign v_hex = (HEX_DIGITS*4)'(v_ext);

    always_comb begin
        oct_slots = '0;
        hex_slots = '0;
        for (int i = 0; i < OCT_DIGITS; i++) begin
            oct_slots[i] = {1'b0, v_oct[3*i +: 3]};
        end
        for (int i = 0; i < HEX_DIGITS; i++) begin
            hex_slots[i] = v_hex[4*i +: 4];
        end
    end

    // add-3 correction on every bcd digit
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            dabble[i] = (dig_reg[i] >= BCD_FIVE) ? (dig_reg[i] + BCD_THREE) : dig_reg[i];
        end
    end

    assign cur_digit  = dig_reg[IDX_W'(cnt_reg - CNT_ONE)];
    assign show_digit = started_reg || (cur_digit != 4'd0) || (cnt_reg <= min_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    case (s_kind) inside
                        KIND_SDEC, KIND_UDEC:            state_next = ST_CONV;
                        KIND_HEXL, KIND_HEXU, KIND_OCT,
                        KIND_ADDR:                       state_next = ST_EMIT;
                        default:                         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV: begin
                if (bit_cnt_reg == BITS_ONE) begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && cnt_reg == CNT_ONE) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        dig_next     = dig_reg;
        bin_next     = bin_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        min_next     = min_reg;
        upper_next   = upper_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    bin_next     = mag;
                    bit_cnt_next = BITS_ALL;
                    neg_next     = v_neg;
                    upper_next   = (s_kind == KIND_HEXU);
                    started_next = 1'b0;
                    min_next     = (s_kind == KIND_ADDR) ? MIN_ADDR : CNT_ONE;
                    case (s_kind) inside
                        KIND_SDEC, KIND_UDEC: begin
                            dig_next = '0;
                            cnt_next = CNT_DEC;
                        end
                        KIND_OCT: begin
                            dig_next = oct_slots;
                            cnt_next = CNT_OCT;
                        end
                        KIND_ADDR: begin
                            dig_next = hex_slots;
                            cnt_next = CNT_ADDR;
                        end
                        default: begin
                            dig_next = hex_slots;
                            cnt_next = CNT_HEX;
                        end
                    endcase
                end
            end
            ST_CONV: begin
                dig_next     = digits_t'({dabble, bin_reg[VALUE_WIDTH-1]});
                bin_next     = bin_reg << 1;
                bit_cnt_next = bit_cnt_reg - BITS_ONE;
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ASCII_MINUS;
                    m_last_next  = 1'b0;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    cnt_next = cnt_reg - CNT_ONE;
                    if (show_digit) begin
                        started_next = 1'b1;
                        m_valid_next = 1'b1;
                        m_char_next  = digit_ascii(cur_digit, upper_reg);
                        m_last_next  = (cnt_reg == CNT_ONE);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg     <= dig_next;
        bin_reg     <= bin_next;
        bit_cnt_reg <= bit_cnt_next;
        cnt_reg     <= cnt_next;
        min_reg     <= min_next;
        upper_reg   <= upper_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

    `ITAF_ASSERT_NOW(a_emit_cnt_live, aclk, aresetn, (state_reg == ST_EMIT), (cnt_reg != '0), "digit count empty while emitting")
    `ITAF_ASSERT_NEXT(a_final_is_last, aclk, aresetn, (state_reg == ST_EMIT && out_free && cnt_reg == CNT_ONE), (m_valid_reg && m_last_reg && state_reg == ST_IDLE), "final digit not marked last")
    `ITAF_ASSERT_NEXT(a_conv_no_word, aclk, aresetn, (state_reg == ST_CONV), (!$rose(m_valid_reg)), "word produced during conversion")
    `ITAF_ASSERT_NEXT(a_sign_is_minus, aclk, aresetn, (state_reg == ST_SIGN && out_free), (m_valid_reg && m_char_reg == ASCII_MINUS && !m_last_reg), "sign word wrong")

endmodule

`default_nettype wire

@@ tb/integer_to_ascii_formatter_tb.sv @@
// testbench for integer_to_ascii_formatter: table-driven and random formats checked per word
`default_nettype none

module integer_to_ascii_formatter_tb
    import itaf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    localparam int MAX_ROWS     = 32;
    localparam int ITEMS_PHASE  = 102;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } char_word_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [2:0]          s_kind  = KIND_SDEC;
    logic [IN_WIDTH-1:0] s_value = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [7:0]          m_character;
    logic                m_last;

    char_word_t pending_chars[$];
    char_word_t head_word;
    int         failures    = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 31;
    int         rx_idle_pct = 74;

    logic [2:0]  row_kind  [MAX_ROWS];
    logic [31:0] row_value [MAX_ROWS];
    string       row_text  [MAX_ROWS];
    int          n_rows = 0;

    integer_to_ascii_formatter u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("integer_to_ascii_formatter test failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected word: character %02h last %b", m_character, m_last);
            end else begin
                head_word = pending_chars.pop_front();
                if (m_character !== head_word.character || m_last !== head_word.last) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("mismatch: expected character %02h last %b, got %02h last %b",
                                 head_word.character, head_word.last, m_character, m_last);
                end
            end
        end
    end

    task automatic format_number(input logic [2:0] kind, input logic [31:0] value,
                                 output logic [7:0] text[$]);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] radix;
        logic [7:0]             alpha;
        logic [7:0]             dig;
        logic                   neg;
        int                     min_len;
        text.delete();
        mag     = VALUE_WIDTH'(value);
        alpha   = LOWER_HEX_OFFSET;
        neg     = 1'b0;
        min_len = 1;
        case (kind)
            KIND_SDEC: begin
                radix = 10;
                if (mag[VALUE_WIDTH-1]) begin
                    neg = 1'b1;
                    mag = ~mag + 1'b1;
                end
            end
            KIND_UDEC: radix = 10;
            KIND_HEXL: radix = 16;
            KIND_HEXU: begin
                radix = 16;
                alpha = UPPER_HEX_OFFSET;
            end
            KIND_OCT:  radix = 8;
            KIND_ADDR: begin
                radix   = 16;
                min_len = ADDRESS_DIGITS;
            end
            default:   return;
        endcase
        do begin
            dig = 8'(mag % radix);
            mag = mag / radix;
            text.push_front((dig > 8'd9) ? dig + alpha : dig + ASCII_ZERO);
        end while (mag != 0);
        while (text.size() < min_len)
            text.push_front(ASCII_ZERO);
        if (neg)
            text.push_front(ASCII_MINUS);
    endtask

    task automatic send_word(input logic [2:0] kind, input logic [31:0] value,
                             input string literal);
        logic [7:0] text[$];
        char_word_t w;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (literal.len() > 0) begin
            for (int i = 0; i < literal.len(); i++)
                text.push_back(literal[i]);
        end else begin
            format_number(kind, value, text);
        end
        for (int i = 0; i < text.size(); i++) begin
            w.character = text[i];
            w.last      = (i == text.size() - 1);
            pending_chars.push_back(w);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge aclk);
    endtask

    task automatic add_row(input logic [2:0] kind, input logic [31:0] value,
                           input string literal);
        row_kind[n_rows]  = kind;
        row_value[n_rows] = value;
        row_text[n_rows]  = literal;
        n_rows++;
    endtask

    initial begin
        logic [2:0]  kind;
        logic [31:0] value;
        int          sent;

        add_row(KIND_SDEC, 32'h0000_0000, "0");
        add_row(KIND_SDEC, 32'h8000_0000, "-2147483648");
        add_row(KIND_SDEC, 32'h7fff_ffff, "2147483647");
        add_row(KIND_SDEC, 32'hffff_ffff, "-1");
        add_row(KIND_SDEC, 32'h8000_0001, "-2147483647");
        add_row(KIND_SDEC, 32'd12345,     "");
        add_row(KIND_UDEC, 32'h0000_0000, "0");
        add_row(KIND_UDEC, 32'hffff_ffff, "4294967295");
        add_row(KIND_UDEC, 32'd1000000000, "");
        add_row(KIND_HEXL, 32'h0000_0000, "0");
        add_row(KIND_HEXL, 32'hffff_ffff, "ffffffff");
        add_row(KIND_HEXL, 32'h0abc_def9, "");
        add_row(KIND_HEXU, 32'h0000_0000, "0");
        add_row(KIND_HEXU, 32'hffff_ffff, "FFFFFFFF");
        add_row(KIND_HEXU, 32'h0abc_def9, "");
        add_row(KIND_OCT,  32'h0000_0000, "0");
        add_row(KIND_OCT,  32'hffff_ffff, "37777777777");
        add_row(KIND_OCT,  32'd8,         "");
        add_row(KIND_ADDR, 32'h0000_0000, "000000000");
        add_row(KIND_ADDR, 32'hffff_ffff, "0ffffffff");
        add_row(KIND_ADDR, 32'h0000_1234, "");
        add_row(KIND_RSVD6, 32'h0000_0000, "");
        add_row(KIND_RSVD7, 32'hffff_ffff, "");

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < n_rows; i++)
            send_word(row_kind[i], row_value[i], row_text[i]);

        // hold off until every character is back
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 74 : 0;
            rx_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 31 : 0;
            sent = 0;
            while (sent < ITEMS_PHASE) begin
                if ($urandom_range(0, 15) < 14)
                    kind = 3'($urandom_range(KIND_SDEC, KIND_ADDR));
                else
                    kind = 3'($urandom_range(KIND_RSVD6, KIND_RSVD7));
                case ($urandom_range(0, 4))
                    0: value = $urandom_range(0, 1000);
                    1: value = $urandom >> $urandom_range(0, 31);
                    2: begin
                        case ($urandom_range(0, 3))
                            0: value = 32'h8000_0000;
                            1: value = 32'h7fff_ffff;
                            2: value = 32'hffff_ffff;
                            default: value = 32'h0000_0000;
                        endcase
                    end
                    default: value = $urandom;
                endcase
                send_word(kind, value, "");
                sent++;
            end
            if (phase == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (failures == 0 && pending_chars.size() == 0) begin
            $display("integer_to_ascii_formatter test passed");
        end else begin
            $display("integer_to_ascii_formatter test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
